// File: rtl/ihc_pkg.sv
// shared types, codes and a helper function for the ipv4 header checker
package ihc_pkg;

    // verdict codes
    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_OTHER   = 2'd1;
    localparam logic [1:0] ST_BAD_VER = 2'd2;
    localparam logic [1:0] ST_CKS_BAD = 2'd3;

    // frame word positions and header constants
    localparam logic [5:0]  ETHERTYPE_WORD = 6'd6;
    localparam logic [5:0]  IP_HDR_WORD    = 6'd7;
    localparam logic [5:0]  CKS_HDR_WORD   = 6'd5;
    localparam logic [5:0]  PROTO_HDR_WORD = 6'd4;
    localparam logic [5:0]  IDX_MAX        = 6'd63;
    localparam logic [4:0]  MIN_SPAN       = 5'd6;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION     = 4'd4;

    // one accepted input transfer
    typedef struct packed {
        logic [15:0] frame_word;
        logic        first_word;
    } in_item_t;

    // one verdict
    typedef struct packed {
        logic [3:0]  header_words32;
        logic [7:0]  protocol;
        logic [15:0] computed_checksum;
        logic [1:0]  status;
    } result_t;

    // two folds cover any sum of up to 32 words
    function automatic logic [15:0] fold_invert(input logic [20:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, s[15:0]} + {12'b0, s[20:16]};
        f2 = {1'b0, f1[15:0]} + {16'b0, f1[16]};
        return ~f2[15:0];
    endfunction

endpackage

// File: rtl/ipv4_header_checker.sv
// The checker takes one 16-bit frame word per cycle and keeps that rate for as long as the
// result side takes verdicts; a word moves from the input register through the header logic
// into the verdict register, which drives the result port, and a waiting verdict stalls
// input only once the input register is full.
// One verdict per frame, none for a frame cut short by a new first word.
module ipv4_header_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // frame_word
    input  logic        s_tuser,   // first_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status, computed_checksum, protocol, header_words32
);

    logic              take;
    logic              item_valid;
    ihc_pkg::in_item_t item;
    logic              res_valid;
    ihc_pkg::result_t  res;

    ihc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_word     (s_tdata),
        .s_first    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ihc_frame_core u_frame_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_tready   (m_tready),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {2'b00, res};

endmodule

// File: rtl/ihc_in_stage.sv
// input register stage that holds one accepted frame word
module ihc_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_word,
    input  logic              s_first,
    input  logic              take,
    output logic              item_valid,
    output ihc_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    ihc_pkg::in_item_t item_reg;
    logic              accept;

    assign s_tready   = !valid_reg || take;
    assign accept     = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.frame_word <= s_word;
            item_reg.first_word <= s_first;
        end
    end

endmodule

// File: rtl/ihc_frame_core.sv
// per-frame header tracking, checksum sum and verdict register
module ihc_frame_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  ihc_pkg::in_item_t item,
    output logic              take,
    input  logic              m_tready,
    output logic              res_valid,
    output ihc_pkg::result_t  res
);

    logic [5:0]  idx_reg,  idx_next;
    logic [20:0] sum_reg,  sum_next;
    logic [15:0] rcks_reg, rcks_next;
    logic        seen_reg, seen_next;
    logic [3:0]  ihl_reg,  ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic        done_reg, done_next;
    logic        out_valid_reg, out_valid_next;
    ihc_pkg::result_t out_reg, out_next;

    logic        go;
    logic        emit;
    logic [5:0]  idx_cur;
    logic [20:0] sum_cur;
    logic [15:0] rcks_cur;
    logic        seen_cur;
    logic [3:0]  ihl_cur;
    logic [7:0]  proto_cur;
    logic        done_cur;
    logic [5:0]  h;
    logic [4:0]  span;
    logic [4:0]  last;
    logic [15:0] w;
    logic [15:0] cks;

    assign take      = !out_valid_reg || m_tready;
    assign go        = item_valid && take;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign w         = item.frame_word;

    always_comb begin
        // a first word restarts the frame state
        if (item.first_word) begin
            idx_cur   = '0;
            sum_cur   = '0;
            rcks_cur  = '0;
            seen_cur  = 1'b0;
            ihl_cur   = '0;
            proto_cur = '0;
            done_cur  = 1'b0;
        end else begin
            idx_cur   = idx_reg;
            sum_cur   = sum_reg;
            rcks_cur  = rcks_reg;
            seen_cur  = seen_reg;
            ihl_cur   = ihl_reg;
            proto_cur = proto_reg;
            done_cur  = done_reg;
        end

        idx_next   = idx_cur;
        sum_next   = sum_cur;
        rcks_next  = rcks_cur;
        seen_next  = seen_cur;
        ihl_next   = ihl_cur;
        proto_next = proto_cur;
        done_next  = done_cur;
        emit       = 1'b0;
        out_next   = out_reg;
        h          = idx_cur - ihc_pkg::IP_HDR_WORD;
        span       = '0;
        last       = '0;
        cks        = '0;

        if (!done_cur) begin
            if (idx_cur < ihc_pkg::IDX_MAX) begin
                idx_next = idx_cur + 6'd1;
            end
            if (idx_cur == ihc_pkg::ETHERTYPE_WORD && w != ihc_pkg::ETHERTYPE_IPV4) begin
                emit      = 1'b1;
                done_next = 1'b1;
                out_next  = '{header_words32: '0, protocol: '0,
                              computed_checksum: '0, status: ihc_pkg::ST_OTHER};
            end else if (idx_cur >= ihc_pkg::IP_HDR_WORD) begin
                if (h == '0) begin
                    ihl_next = w[11:8];
                end
                if (h == '0 && w[15:12] != ihc_pkg::IP_VERSION) begin
                    emit      = 1'b1;
                    done_next = 1'b1;
                    out_next  = '{header_words32: w[11:8], protocol: '0,
                                  computed_checksum: '0, status: ihc_pkg::ST_BAD_VER};
                end else begin
                    span = {ihl_next, 1'b0};
                    if (h < {1'b0, span} && h != ihc_pkg::CKS_HDR_WORD) begin
                        sum_next = sum_cur + {5'b0, w};
                    end
                    if (h == ihc_pkg::PROTO_HDR_WORD) begin
                        proto_next = w[7:0];
                    end
                    if (h == ihc_pkg::CKS_HDR_WORD) begin
                        rcks_next = w;
                        seen_next = 1'b1;
                    end
                    last = ((span > ihc_pkg::MIN_SPAN) ? span : ihc_pkg::MIN_SPAN) - 5'd1;
                    cks  = ihc_pkg::fold_invert(sum_next);
                    if (h == {1'b0, last} && seen_next) begin
                        emit      = 1'b1;
                        done_next = 1'b1;
                        out_next  = '{header_words32: ihl_next, protocol: proto_next,
                                      computed_checksum: cks,
                                      status: (cks == rcks_next) ? ihc_pkg::ST_VALID
                                                                 : ihc_pkg::ST_CKS_BAD};
                    end
                end
            end
        end

        if (go && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            rcks_reg      <= '0;
            seen_reg      <= 1'b0;
            ihl_reg       <= '0;
            proto_reg     <= '0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (go) begin
                idx_reg   <= idx_next;
                sum_reg   <= sum_next;
                rcks_reg  <= rcks_next;
                seen_reg  <= seen_next;
                ihl_reg   <= ihl_next;
                proto_reg <= proto_next;
                done_reg  <= done_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go && emit) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/ihc_checker.sv
// port-level checks for the ipv4 header checker and their bind
module ihc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("verdict valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled verdict changed");

    a_other_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == ihc_pkg::ST_OTHER |-> m_tdata[31:2] == '0)
        else $error("other ethertype verdict carries fields");

    a_bad_ver_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == ihc_pkg::ST_BAD_VER |-> m_tdata[25:2] == '0)
        else $error("bad version verdict carries checksum or protocol");

endmodule

bind ipv4_header_checker ihc_checker u_ihc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb_ipv4_header_checker.sv
`timescale 1ns / 100ps
// self-checking testbench for the ipv4 header checker: directed word table, then random frames
module tb_ipv4_header_checker;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int LIVE_TARGET    = 450;
    localparam int VERDICT_TARGET = 40;
    localparam int IDLE_PCT       = 18;
    localparam int HOLD_AT        = 120;
    localparam int HOLD_CYCLES    = 300;
    localparam int CALM_FROM      = 300;
    localparam int CALM_TO        = 420;
    localparam int DRAIN_AT_FRAME = 12;
    localparam int SETTLE_CYCLES  = 12;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_PRINTS     = 60;
    localparam int NUM_ROWS       = 31;

    typedef struct packed {
        logic [15:0]      word;
        logic             first;
        logic             fixed;   // verdict typed in below instead of predicted
        ihc_pkg::result_t want;
    } stim_row_t;

    localparam ihc_pkg::result_t NO_VERDICT = '0;

    // idle word, a frame cut short, other ethertype, bad version, zero ihl
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'h1234, 1'b1, 1'b0, NO_VERDICT},
        '{16'h5678, 1'b0, 1'b0, NO_VERDICT},
        '{16'h0000, 1'b1, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'h0000, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'h0000, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b1, '{4'd0, 8'h00, 16'h0000, ihc_pkg::ST_OTHER}},
        '{16'hFFFF, 1'b1, 1'b0, NO_VERDICT},
        '{16'h0000, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'h0000, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'h0000, 1'b0, 1'b0, NO_VERDICT},
        '{16'h0800, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b1, '{4'hF, 8'h00, 16'h0000, ihc_pkg::ST_BAD_VER}},
        '{16'h0000, 1'b1, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'h0000, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'h0000, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'h0800, 1'b0, 1'b0, NO_VERDICT},
        '{16'h4000, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'h0000, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b0, NO_VERDICT},
        '{16'h00FF, 1'b0, 1'b0, NO_VERDICT},
        '{16'hFFFF, 1'b0, 1'b1, '{4'd0, 8'hFF, 16'hFFFF, ihc_pkg::ST_VALID}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // checker state mirrored on the testbench side
    logic [5:0]  pos_q      = '0;
    logic [20:0] hdr_sum    = '0;
    logic [15:0] rx_cks     = '0;
    logic        cks_seen   = 1'b0;
    logic [3:0]  ihl_q      = '0;
    logic [7:0]  proto_q    = '0;
    logic        frame_idle = 1'b1;

    ihc_pkg::result_t verdict_q [$];
    int      errors          = 0;
    int      cycles          = 0;
    int      words_sent      = 0;
    int      live_words      = 0;
    int      frames_sent     = 0;
    int      verdicts_queued = 0;
    int      verdicts_checked = 0;
    int      status_seen [4] = '{0, 0, 0, 0};
    int      hold_left       = 0;
    bit      hold_used       = 1'b0;

    ipv4_header_checker u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // frame_word
        .s_tuser  (s_tuser),   // first_word
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, computed_checksum, protocol, header_words32
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic logic [15:0] cks_of_sum(input logic [20:0] s);
        logic [21:0] acc;
        acc = {1'b0, s};
        while (acc[21:16] != '0)
            acc = {6'b0, acc[15:0]} + {16'b0, acc[21:16]};
        return ~acc[15:0];
    endfunction

    // no idling at all while the word count sits in the calm window
    function automatic bit idle_roll();
        if (live_words >= CALM_FROM && live_words < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    task automatic predict_word(input logic [15:0] w, input logic first, output bit live,
                                output bit has_verdict, output ihc_pkg::result_t v);
        logic [5:0] at;
        int h;
        int span;
        int last_h;
        live = 1'b0;
        has_verdict = 1'b0;
        v = '0;
        if (first) begin
            pos_q = '0;
            hdr_sum = '0;
            rx_cks = '0;
            cks_seen = 1'b0;
            ihl_q = '0;
            proto_q = '0;
            frame_idle = 1'b0;
        end
        if (!frame_idle) begin
            live = 1'b1;
            at = pos_q;
            if (pos_q != ihc_pkg::IDX_MAX)
                pos_q = pos_q + 6'd1;
            if (at == ihc_pkg::ETHERTYPE_WORD && w != ihc_pkg::ETHERTYPE_IPV4) begin
                v.status = ihc_pkg::ST_OTHER;
                has_verdict = 1'b1;
                frame_idle = 1'b1;
            end else if (at >= ihc_pkg::IP_HDR_WORD) begin
                h = int'(at - ihc_pkg::IP_HDR_WORD);
                if (h == 0) begin
                    ihl_q = w[11:8];
                    if (w[15:12] != ihc_pkg::IP_VERSION) begin
                        v.status = ihc_pkg::ST_BAD_VER;
                        v.header_words32 = ihl_q;
                        has_verdict = 1'b1;
                        frame_idle = 1'b1;
                    end
                end
                if (!has_verdict) begin
                    span = 2 * int'(ihl_q);
                    if (h < span && h != int'(ihc_pkg::CKS_HDR_WORD))
                        hdr_sum = hdr_sum + {5'b0, w};
                    if (h == int'(ihc_pkg::PROTO_HDR_WORD))
                        proto_q = w[7:0];
                    if (h == int'(ihc_pkg::CKS_HDR_WORD)) begin
                        rx_cks = w;
                        cks_seen = 1'b1;
                    end
                    // checksum word is always read, so short headers still wait for it
                    last_h = ((span > int'(ihc_pkg::MIN_SPAN)) ? span
                                                              : int'(ihc_pkg::MIN_SPAN)) - 1;
                    if (h == last_h && cks_seen) begin
                        v.computed_checksum = cks_of_sum(hdr_sum);
                        v.status = (v.computed_checksum == rx_cks) ? ihc_pkg::ST_VALID
                                                                   : ihc_pkg::ST_CKS_BAD;
                        v.protocol = proto_q;
                        v.header_words32 = ihl_q;
                        has_verdict = 1'b1;
                        frame_idle = 1'b1;
                    end
                end
            end
        end
    endtask

    // valid stays high between back-to-back words and only drops during a gap
    task automatic send_word(input logic [15:0] w, input logic first, input bit fixed,
                             input ihc_pkg::result_t want);
        bit live;
        bit has_v;
        ihc_pkg::result_t v;
        while (idle_roll()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= first;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent++;
        predict_word(w, first, live, has_v, v);
        if (live)
            live_words++;
        if (fixed) begin
            has_v = 1'b1;
            v = want;
        end
        if (has_v) begin
            verdict_q.push_back(v);
            verdicts_queued++;
        end
    endtask

    task automatic wait_verdicts();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_frame();
        logic [15:0] fw [48];
        logic [15:0] hdr [30];
        logic [20:0] acc;
        logic [3:0]  ihl;
        logic [3:0]  ver;
        int span;
        int nhdr;
        int n;
        int extra;
        int k;
        ihl = ($urandom_range(99) < 70) ? 4'd5 : 4'($urandom_range(15));
        ver = ($urandom_range(99) < 8) ? 4'($urandom) : ihc_pkg::IP_VERSION;
        span = 2 * int'(ihl);
        for (k = 0; k < 30; k++)
            hdr[k] = 16'($urandom);
        hdr[0] = {ver, ihl, hdr[0][7:0]};
        acc = '0;
        for (k = 0; k < span; k++)
            if (k != int'(ihc_pkg::CKS_HDR_WORD))
                acc = acc + {5'b0, hdr[k]};
        if ($urandom_range(99) < 70)
            hdr[ihc_pkg::CKS_HDR_WORD] = cks_of_sum(acc);
        for (k = 0; k < int'(ihc_pkg::ETHERTYPE_WORD); k++)
            fw[k] = 16'($urandom);
        fw[ihc_pkg::ETHERTYPE_WORD] = ($urandom_range(99) < 8) ? 16'($urandom)
                                                               : ihc_pkg::ETHERTYPE_IPV4;
        nhdr = (span > int'(ihc_pkg::MIN_SPAN)) ? span : int'(ihc_pkg::MIN_SPAN);
        for (k = 0; k < nhdr; k++)
            fw[int'(ihc_pkg::IP_HDR_WORD) + k] = hdr[k];
        n = int'(ihc_pkg::IP_HDR_WORD) + nhdr;
        if ($urandom_range(99) < 5) begin
            n = $urandom_range(n - 1, 1);
        end else begin
            // trailing payload words land after the verdict and are dropped
            extra = $urandom_range(3);
            for (k = 0; k < extra; k++)
                fw[n + k] = 16'($urandom);
            n = n + extra;
        end
        for (k = 0; k < n; k++)
            send_word(fw[k], (k == 0), 1'b0, NO_VERDICT);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch on %s at verdict %0d: got 0x%0h, expected 0x%0h",
                     what, verdicts_checked, got, want);
    endtask

    task automatic check_verdict();
        ihc_pkg::result_t got;
        ihc_pkg::result_t want;
        got = ihc_pkg::result_t'(m_tdata[$bits(ihc_pkg::result_t)-1:0]);
        status_seen[got.status]++;
        if (verdict_q.size() == 0) begin
            flag_mismatch("unexpected verdict", m_tdata, '0);
            return;
        end
        want = verdict_q.pop_front();
        if (got.status != want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.computed_checksum != want.computed_checksum)
            flag_mismatch("computed_checksum", 32'(got.computed_checksum),
                          32'(want.computed_checksum));
        if (got.protocol != want.protocol)
            flag_mismatch("protocol", 32'(got.protocol), 32'(want.protocol));
        if (got.header_words32 != want.header_words32)
            flag_mismatch("header_words32", 32'(got.header_words32),
                          32'(want.header_words32));
        verdicts_checked++;
    endtask

    // result side: random stalls plus one long hold-off that backs up the input
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_verdict();
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_used && live_words >= HOLD_AT) begin
            m_tready <= 1'b0;
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= !idle_roll();
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycles, verdict_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < NUM_ROWS; i++)
            send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].first,
                      DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
        wait_verdicts();
        while (live_words < LIVE_TARGET || verdicts_queued < VERDICT_TARGET) begin
            send_frame();
            frames_sent++;
            if (frames_sent == DRAIN_AT_FRAME)
                wait_verdicts();
        end
        wait_verdicts();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("sent %0d words (%0d inside frames) over %0d directed rows and %0d frames",
                 words_sent, live_words, NUM_ROWS, frames_sent);
        $display("verdicts: %0d valid, %0d other ethertype, %0d bad version, %0d bad checksum",
                 status_seen[ihc_pkg::ST_VALID], status_seen[ihc_pkg::ST_OTHER],
                 status_seen[ihc_pkg::ST_BAD_VER], status_seen[ihc_pkg::ST_CKS_BAD]);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
